### hw/rtl/prm_pkg.sv
// Shared types, constants and the band classifier for the pulse rate meter.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package prm_pkg;

  // Batch and counter sizing
  localparam int BEATS_PER_BATCH = 10;
  localparam int TICK_COUNT_BITS = 24;

  // Field widths
  localparam int THR_W   = 8;
  localparam int BPM_W   = 16;
  localparam int BAND_W  = 3;
  localparam int NUM_THR = 7;

  // Derived widths
  localparam int EDGE_W    = $clog2(BEATS_PER_BATCH);
  localparam int DIV_CNT_W = $clog2(TICK_COUNT_BITS + 1);
  localparam int CFG_IDX_W = $clog2(NUM_THR);

  localparam int MS_PER_MINUTE = 60000;

  typedef logic [TICK_COUNT_BITS-1:0] ticks_t;
  typedef logic [THR_W-1:0]           thr_t;
  typedef thr_t [NUM_THR-1:0]         thr_bank_t;
  typedef logic [BPM_W-1:0]           bpm_t;
  typedef logic [BAND_W-1:0]          band_t;

  localparam ticks_t TICK_MAX = '1;

  // Threshold reset values, entry 0 in the low byte
  localparam thr_bank_t THR_RESET = {8'd82, 8'd74, 8'd70, 8'd66, 8'd62, 8'd56, 8'd50};

  // Event from the edge tracker: closing edge with the batch span
  typedef struct packed {
    logic   close;
    ticks_t ticks;
    logic   sat;
  } batch_evt_t;

  // Priority chain: band grows while the rate clears each threshold in order
  function automatic band_t classify(bpm_t rate, thr_bank_t thr);
    band_t band;
    logic  stop;
    band = '0;
    stop = 1'b0;
    for (int i = 0; i < NUM_THR; i++) begin
      if (!stop && (rate >= {{(BPM_W-THR_W){1'b0}}, thr[i]})) begin
        band = band + band_t'(1);
      end else begin
        stop = 1'b1;
      end
    end
    return band;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/prm_edge_track.sv
// Rising edge detector, per-batch edge count and saturating tick counter.
// Depends on prm_pkg.
`default_nettype none

module prm_edge_track (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic                level,
  output prm_pkg::batch_evt_t      evt
);

  logic                       last_level, last_level_next;
  logic [prm_pkg::EDGE_W-1:0] edges_seen, edges_seen_next;
  prm_pkg::ticks_t            batch_ticks, batch_ticks_next;
  logic                       ticks_sat, ticks_sat_next;

  logic            rising;
  logic            active;
  logic            close;
  prm_pkg::ticks_t ticks_inc;
  logic            sat_inc;

  // Counter advance for this tick, then edge bookkeeping
  always_comb begin
    rising    = level && !last_level;
    active    = (edges_seen != '0);
    ticks_inc = batch_ticks;
    sat_inc   = ticks_sat;
    if (active) begin
      if (batch_ticks == prm_pkg::TICK_MAX) begin
        sat_inc = 1'b1;
      end else begin
        ticks_inc = batch_ticks + prm_pkg::ticks_t'(1);
      end
    end
    close = rising && active &&
            (edges_seen == prm_pkg::EDGE_W'(prm_pkg::BEATS_PER_BATCH - 1));

    last_level_next  = last_level;
    edges_seen_next  = edges_seen;
    batch_ticks_next = batch_ticks;
    ticks_sat_next   = ticks_sat;
    if (step) begin
      last_level_next  = level;
      batch_ticks_next = ticks_inc;
      ticks_sat_next   = sat_inc;
      if (rising) begin
        if (!active) begin
          batch_ticks_next = '0;
          ticks_sat_next   = 1'b0;
          edges_seen_next  = prm_pkg::EDGE_W'(1);
        end else if (close) begin
          // closing edge does not open the next batch
          batch_ticks_next = '0;
          ticks_sat_next   = 1'b0;
          edges_seen_next  = '0;
        end else begin
          edges_seen_next = edges_seen + prm_pkg::EDGE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level  <= 1'b0;
      edges_seen  <= '0;
      batch_ticks <= '0;
      ticks_sat   <= 1'b0;
    end else begin
      last_level  <= last_level_next;
      edges_seen  <= edges_seen_next;
      batch_ticks <= batch_ticks_next;
      ticks_sat   <= ticks_sat_next;
    end
  end

  assign evt.close = close;
  assign evt.ticks = ticks_inc;
  assign evt.sat   = sat_inc;

endmodule

`default_nettype wire

### hw/rtl/prm_serial_div.sv
// Restoring divider: one quotient bit per cycle shifted into a register.
// Depends on prm_pkg. Division by zero yields all ones.
`default_nettype none

module prm_serial_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire prm_pkg::ticks_t dividend,
  input  wire prm_pkg::ticks_t divisor,
  output logic                 busy,
  output logic                 done,
  output prm_pkg::ticks_t      quotient
);

  localparam int W = prm_pkg::TICK_COUNT_BITS;

  logic [prm_pkg::DIV_CNT_W-1:0] cnt;
  prm_pkg::ticks_t               rem;
  prm_pkg::ticks_t               quo;
  prm_pkg::ticks_t               dsr;

  logic [W:0]   partial;
  logic [W+1:0] diff;
  logic         qbit;

  // One trial subtraction per cycle
  always_comb begin
    partial = {rem, quo[W-1]};
    diff    = {1'b0, partial} - {2'b00, dsr};
    qbit    = !diff[W+1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt - prm_pkg::DIV_CNT_W'(1);
        if (cnt == prm_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= prm_pkg::DIV_CNT_W'(W);
      end
    end
  end

  // Datapath: dividend shifts out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= qbit ? diff[W-1:0] : partial[W-1:0];
      quo <= {quo[W-2:0], qbit};
    end else if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

### hw/rtl/pulse_rate_meter_classifier.sv
// Pulse rate meter: a closing-edge tick yields one result, computed by two passes of the shared
// bit-serial divider (sum / (beats-1), then 60000 / mean). Other ticks produce no result;
// input is stalled from a closing-edge transfer until its result is loaded into the output
// registers.
// Synchronous active-high reset clears batch state, thresholds to defaults, output empty.
// Depends on prm_pkg, prm_edge_track, prm_serial_div.
`default_nettype none

module pulse_rate_meter_classifier (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [prm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [prm_pkg::THR_W-1:0]           cfg_data,
  // tick input
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                pulse_level,
  // results
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [prm_pkg::BPM_W-1:0]                beats_per_minute,
  output logic [prm_pkg::BAND_W-1:0]               rate_band,
  output logic                                     span_saturated
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DIV_MEAN = 2'd1;
  localparam logic [1:0] ST_DIV_RATE = 2'd2;
  localparam logic [1:0] ST_OUT      = 2'd3;

  logic [1:0] state, state_next;

  prm_pkg::thr_bank_t  thr;
  prm_pkg::batch_evt_t evt;

  logic            in_xfer;
  logic            div_start;
  prm_pkg::ticks_t div_dividend;
  prm_pkg::ticks_t div_divisor;
  logic            div_busy;
  logic            div_done;
  prm_pkg::ticks_t div_quo;

  logic          sat_hold;
  logic          mean_zero;
  prm_pkg::bpm_t bpm;
  logic          out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Threshold registers; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= prm_pkg::THR_RESET;
    end else if (cfg_valid && (cfg_index < prm_pkg::CFG_IDX_W'(prm_pkg::NUM_THR))) begin
      thr[cfg_index] <= cfg_data;
    end
  end

  prm_edge_track u_edge (
    .clk   (clk),
    .rst   (rst),
    .step  (in_xfer),
    .level (pulse_level),
    .evt   (evt)
  );

  // Divider operand select: first pass mean, second pass rate
  always_comb begin
    div_start    = 1'b0;
    div_dividend = evt.ticks;
    div_divisor  = prm_pkg::ticks_t'(prm_pkg::BEATS_PER_BATCH - 1);
    if (state == ST_DIV_MEAN) begin
      div_start    = div_done;
      div_dividend = prm_pkg::ticks_t'(prm_pkg::MS_PER_MINUTE);
      div_divisor  = div_quo;
    end else begin
      div_start = in_xfer && evt.close;
    end
  end

  prm_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_xfer && evt.close) state_next = ST_DIV_MEAN;
      ST_DIV_MEAN: if (div_done) state_next = ST_DIV_RATE;
      ST_DIV_RATE: if (div_done) state_next = ST_OUT;
      ST_OUT:      if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Batch payload holding registers
  always_ff @(posedge clk) begin
    if (in_xfer && evt.close) begin
      sat_hold <= evt.sat;
    end
    if (state == ST_DIV_MEAN && div_done) begin
      mean_zero <= (div_quo == '0);
    end
    if (state == ST_DIV_RATE && div_done) begin
      bpm <= mean_zero ? prm_pkg::BPM_W'(prm_pkg::MS_PER_MINUTE)
                       : div_quo[prm_pkg::BPM_W-1:0];
    end
    if (state == ST_OUT && out_free) begin
      beats_per_minute <= bpm;
      rate_band        <= prm_pkg::classify(bpm, thr);
      span_saturated   <= sat_hold;
    end
  end

  // Checks
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_busy)
    else $error("divider busy while accepting ticks");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ((state == ST_DIV_MEAN) || (state == ST_DIV_RATE)))
    else $error("divider finished outside a divide phase");

  a_bpm_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_OUT) && out_free) |=> (beats_per_minute <= prm_pkg::BPM_W'(60000)))
    else $error("rate above 60000");

endmodule

`default_nettype wire
